[design/aimd_congestion_window_macros.svh]
// Assertion macros for the congestion window RTL.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef AIMD_CONGESTION_WINDOW_MACROS_SVH
`define AIMD_CONGESTION_WINDOW_MACROS_SVH

// Checked only while out of reset.
`define AIMD_CW_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, including during reset.
`define AIMD_CW_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/aimd_cw_pkg.sv]
// Shared types, widths and constants for the AIMD congestion window block.
// Used by aimd_cw_alu and aimd_congestion_window; depends on nothing.
`default_nettype none

package aimd_cw_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WIN_W        = 21;
    localparam int WHOLE_W      = WIN_W - FRAC_BITS;
    localparam int THR_W        = 32;
    localparam int STEP_W       = 20;
    localparam int COEF_W       = 16;
    localparam int SEGMENT_BITS = 32;
    localparam int CMD_W        = 2;
    localparam int PROD_W       = WIN_W + COEF_W;
    localparam int ADD_W        = PROD_W + 1;
    localparam int CNT_W        = $clog2(STEP_W + 1);
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;

    localparam int WINDOW_CAP   = 30;
    localparam int WIN_MAX      = (1 << WIN_W) - 1;
    localparam int CAP_RAW      = WINDOW_CAP << FRAC_BITS;
    localparam logic [WIN_W-1:0] WIN_CAP_Q =
        (CAP_RAW > WIN_MAX) ? WIN_W'(WIN_MAX) : WIN_W'(CAP_RAW);

    // Lower bound of the threshold after a loss: 2.0 in fixed point.
    localparam logic [WIN_W-1:0] MIN_THRESHOLD = WIN_W'(2 << FRAC_BITS);

    localparam logic [WIN_W-1:0]  RST_INIT_WINDOW    = WIN_W'(1 << FRAC_BITS);
    localparam logic [THR_W-1:0]  RST_INIT_THRESHOLD = '1;
    localparam logic [STEP_W-1:0] RST_INCREASE_STEP  = STEP_W'(1 << FRAC_BITS);
    localparam logic [COEF_W-1:0] RST_DECREASE_COEF  = COEF_W'(1 << (COEF_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WINDOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REACT_EVERY_LOSS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_TO_INITIAL  = 3'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_SENT = 2'd0,
        CMD_DATA = 2'd1,
        CMD_LOSS = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [SEGMENT_BITS-1:0] segment_number;
    } event_t;

    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [WHOLE_W-1:0] window_whole;
        logic [THR_W-1:0]   threshold;
        logic               loss_reacted;
    } result_t;

    function automatic logic [WIN_W-1:0] sat_window(input logic [WIN_W:0] w);
        return (w > {1'b0, WIN_CAP_Q}) ? WIN_CAP_Q : w[WIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/aimd_cw_alu.sv]
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide
// on one adder. Depends on aimd_cw_pkg.
`default_nettype none

module aimd_cw_alu
    import aimd_cw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire alu_req_t           req,
    input  wire logic [WIN_W-1:0]   mcand,
    input  wire logic [WHOLE_W-1:0] divisor,
    input  wire logic [STEP_W-1:0]  operand,
    output alu_stat_t               stat,
    output logic [PROD_W-1:0]       product,
    output logic [STEP_W-1:0]       quotient
);

    alu_op_t             op_reg,      op_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic                done_reg,    done_next;
    logic [STEP_W-1:0]   shift_reg,   shift_next;
    logic [PROD_W-1:0]   acc_reg,     acc_next;
    logic [WIN_W-1:0]    mcand_reg,   mcand_next;
    logic [WHOLE_W-1:0]  divisor_reg, divisor_next;

    logic                bit_in;
    logic [WHOLE_W:0]    rem_shift;
    logic [ADD_W-1:0]    add_a;
    logic [ADD_W-1:0]    add_b;
    logic [ADD_W-1:0]    sum;
    logic                fits;

    // One adder serves both operations. For division it subtracts the
    // divisor from the shifted remainder; a clear top bit means no borrow.
    always_comb
    begin
        bit_in    = shift_reg[STEP_W-1];
        rem_shift = {acc_reg[WHOLE_W-1:0], bit_in};
        if (op_reg == ALU_MUL)
        begin
            add_a = {acc_reg, 1'b0};
            add_b = bit_in ? ADD_W'(mcand_reg) : '0;
        end
        else
        begin
            add_a = ADD_W'(rem_shift);
            add_b = ~ADD_W'(divisor_reg);
        end
        sum  = add_a + add_b + ADD_W'(op_reg == ALU_DIV);
        fits = !sum[ADD_W-1];
    end

    always_comb
    begin
        op_next      = op_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        shift_next   = shift_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        divisor_next = divisor_reg;

        if (req.start)
        begin
            op_next      = req.op;
            acc_next     = '0;
            mcand_next   = mcand;
            divisor_next = divisor;
            if (req.op == ALU_MUL)
            begin
                // Multiplier bits are consumed from the top of the shifter.
                shift_next = operand << (STEP_W - COEF_W);
                count_next = CNT_W'(COEF_W);
            end
            else
            begin
                shift_next = operand;
                count_next = CNT_W'(STEP_W);
            end
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CNT_W'(1));
            if (op_reg == ALU_MUL)
            begin
                acc_next   = sum[PROD_W-1:0];
                shift_next = {shift_reg[STEP_W-2:0], 1'b0};
            end
            else
            begin
                acc_next   = fits ? PROD_W'(sum[WHOLE_W-1:0])
                                  : PROD_W'(rem_shift[WHOLE_W-1:0]);
                shift_next = {shift_reg[STEP_W-2:0], fits};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= ALU_MUL;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            op_reg    <= op_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy = (count_reg != '0);
    assign stat.done = done_reg;
    assign product   = acc_reg;
    assign quotient  = shift_reg;

endmodule

`default_nettype wire

[design/aimd_congestion_window.sv]
// Top level of the AIMD congestion window block: event sequencer, state and
// configuration registers, output register. Depends on aimd_cw_pkg, aimd_cw_alu and the macros header.
`default_nettype none
`include "aimd_congestion_window_macros.svh"

// Each accepted request produces exactly one result holding the window,
// its integer part, the threshold and whether a loss reaction set the window.
// Sent events, slow-start data events, unknown commands and losses that are
// ignored within a round trip go from acceptance through the write state to
// the result. A data event in congestion avoidance first runs the 20-step
// serial divide of the increase step by the window's integer part; a loss
// that reacts first runs the 16-step serial multiply by the decrease
// coefficient. Both run on the one shared arithmetic unit, and the block
// takes one request at a time. A finished result sits in an output register,
// so a new request is taken while it waits to be read.
module aimd_congestion_window
    import aimd_cw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 event_valid,
    output logic                      event_stall,
    input  wire event_t               event_data,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WRITE
    } state_t;

    state_t                   state_reg,        state_next;
    alu_op_t                  pend_op_reg,      pend_op_next;
    logic                     reacted_reg,      reacted_next;
    logic [WIN_W-1:0]         cwnd_reg,         cwnd_next;
    logic [THR_W-1:0]         ssthresh_reg,     ssthresh_next;
    logic [SEGMENT_BITS-1:0]  recovery_reg,     recovery_next;
    logic [SEGMENT_BITS-1:0]  high_recv_reg,    high_recv_next;
    logic [SEGMENT_BITS-1:0]  high_req_reg,     high_req_next;
    logic [WIN_W-1:0]         init_window_reg,  init_window_next;
    logic [THR_W-1:0]         init_thr_reg,     init_thr_next;
    logic [STEP_W-1:0]        step_reg,         step_next;
    logic [COEF_W-1:0]        coef_reg,         coef_next;
    logic                     every_loss_reg,   every_loss_next;
    logic                     to_initial_reg,   to_initial_next;
    logic                     result_valid_reg, result_valid_next;
    result_t                  result_reg,       result_next;

    alu_req_t                 alu_req;
    alu_stat_t                alu_stat;
    logic [PROD_W-1:0]        alu_product;
    logic [STEP_W-1:0]        alu_quotient;

    logic                     accept;
    logic [WHOLE_W-1:0]       whole;
    logic [WHOLE_W-1:0]       divisor;
    logic                     slow_start;
    logic                     loss_go;
    logic [WIN_W-1:0]         lowered;
    logic [WIN_W-1:0]         loss_window;

    aimd_cw_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (alu_req),
        .mcand    (cwnd_reg),
        .divisor  (divisor),
        .operand  (alu_req.op == ALU_MUL ? STEP_W'(coef_reg) : step_reg),
        .stat     (alu_stat),
        .product  (alu_product),
        .quotient (alu_quotient)
    );

    assign accept      = event_valid && !event_stall;
    assign event_stall = (state_reg != S_IDLE);

    always_comb
    begin
        whole      = cwnd_reg[WIN_W-1:FRAC_BITS];
        divisor    = (whole == '0) ? WHOLE_W'(1) : whole;
        slow_start = THR_W'(cwnd_reg) < ssthresh_reg;
        loss_go    = every_loss_reg || (high_recv_reg > recovery_reg);

        // The truncated product never exceeds the window width.
        lowered     = alu_product[PROD_W-1:FRAC_BITS];
        if (lowered < MIN_THRESHOLD)
        begin
            lowered = MIN_THRESHOLD;
        end
        loss_window = to_initial_reg ? init_window_reg : lowered;

        alu_req.start = 1'b0;
        alu_req.op    = ALU_DIV;
        if (accept && event_data.cmd == CMD_DATA && !slow_start)
        begin
            alu_req.start = 1'b1;
        end
        else if (accept && event_data.cmd == CMD_LOSS && loss_go)
        begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_MUL;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        pend_op_next      = pend_op_reg;
        reacted_next      = reacted_reg;
        cwnd_next         = cwnd_reg;
        ssthresh_next     = ssthresh_reg;
        recovery_next     = recovery_reg;
        high_recv_next    = high_recv_reg;
        high_req_next     = high_req_reg;
        init_window_next  = init_window_reg;
        init_thr_next     = init_thr_reg;
        step_next         = step_reg;
        coef_next         = coef_reg;
        every_loss_next   = every_loss_reg;
        to_initial_next   = to_initial_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    reacted_next = 1'b0;
                    state_next   = S_WRITE;
                    case (event_data.cmd)
                        CMD_SENT:
                        begin
                            high_req_next = event_data.segment_number;
                        end
                        CMD_DATA:
                        begin
                            if (event_data.segment_number > high_recv_reg)
                            begin
                                high_recv_next = event_data.segment_number;
                            end
                            if (slow_start)
                            begin
                                cwnd_next = sat_window({1'b0, cwnd_reg} +
                                                       (WIN_W + 1)'(step_reg));
                            end
                            else
                            begin
                                pend_op_next = ALU_DIV;
                                state_next   = S_CALC;
                            end
                        end
                        CMD_LOSS:
                        begin
                            if (loss_go)
                            begin
                                recovery_next = high_req_reg;
                                pend_op_next  = ALU_MUL;
                                state_next    = S_CALC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                if (alu_stat.done)
                begin
                    if (pend_op_reg == ALU_DIV)
                    begin
                        cwnd_next = sat_window({1'b0, cwnd_reg} +
                                               (WIN_W + 1)'(alu_quotient));
                    end
                    else
                    begin
                        ssthresh_next = THR_W'(lowered);
                        cwnd_next     = sat_window({1'b0, loss_window});
                        reacted_next  = 1'b1;
                    end
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.window       = cwnd_reg;
                    result_next.window_whole = cwnd_reg[WIN_W-1:FRAC_BITS];
                    result_next.threshold    = ssthresh_reg;
                    result_next.loss_reacted = reacted_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Loading an initial value also loads the live value, uncapped.
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_INIT_WINDOW:
                begin
                    init_window_next = cfg_data[WIN_W-1:0];
                    cwnd_next        = cfg_data[WIN_W-1:0];
                end
                CFG_INIT_THRESHOLD:
                begin
                    init_thr_next = cfg_data[THR_W-1:0];
                    ssthresh_next = cfg_data[THR_W-1:0];
                end
                CFG_INCREASE_STEP:    step_next       = cfg_data[STEP_W-1:0];
                CFG_DECREASE_FACTOR:  coef_next       = cfg_data[COEF_W-1:0];
                CFG_REACT_EVERY_LOSS: every_loss_next = cfg_data[0];
                CFG_LOSS_TO_INITIAL:  to_initial_next = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pend_op_reg      <= ALU_MUL;
            reacted_reg      <= 1'b0;
            cwnd_reg         <= RST_INIT_WINDOW;
            ssthresh_reg     <= RST_INIT_THRESHOLD;
            recovery_reg     <= '0;
            high_recv_reg    <= '0;
            high_req_reg     <= '0;
            init_window_reg  <= RST_INIT_WINDOW;
            init_thr_reg     <= RST_INIT_THRESHOLD;
            step_reg         <= RST_INCREASE_STEP;
            coef_reg         <= RST_DECREASE_COEF;
            every_loss_reg   <= 1'b0;
            to_initial_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_op_reg      <= pend_op_next;
            reacted_reg      <= reacted_next;
            cwnd_reg         <= cwnd_next;
            ssthresh_reg     <= ssthresh_next;
            recovery_reg     <= recovery_next;
            high_recv_reg    <= high_recv_next;
            high_req_reg     <= high_req_next;
            init_window_reg  <= init_window_next;
            init_thr_reg     <= init_thr_next;
            step_reg         <= step_next;
            coef_reg         <= coef_next;
            every_loss_reg   <= every_loss_next;
            to_initial_reg   <= to_initial_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    `AIMD_CW_ASSERT(a_start_from_idle, clk, rst_n, alu_req.start |-> state_reg == S_IDLE, "arithmetic unit started outside idle")
    `AIMD_CW_ASSERT(a_done_in_calc, clk, rst_n, alu_stat.done |-> state_reg == S_CALC, "arithmetic result arrived with no operation pending")
    `AIMD_CW_ASSERT(a_busy_stalls, clk, rst_n, alu_stat.busy |-> event_stall, "request taken while the arithmetic unit is busy")
    `AIMD_CW_ASSERT_ALWAYS(a_react_floor, clk, (result_valid && result_data.loss_reacted) |-> result_data.threshold >= THR_W'(MIN_THRESHOLD), "threshold below floor after a loss reaction")

endmodule

`default_nettype wire
